FILE: hdl/smoothed_valve_conductance_assert.svh
// Assertion macros used by the smoothed valve conductance top level
`ifndef SMOOTHED_VALVE_CONDUCTANCE_ASSERT_SVH
`define SMOOTHED_VALVE_CONDUCTANCE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SVC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("svc assertion failed");

// Implication whose consequent is a delayed sequence
`define SVC_ASSERT_SEQ(label, ante, seq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> seq) \
        else $error("svc assertion failed");

`endif

FILE: hdl/svc_pkg.sv
// Shared types, constants and the divider step for the smoothed valve conductance block
package svc_pkg;

    localparam int FRAC       = 16;               // fraction bits of every field
    localparam int SFRAC      = 30;               // fraction bits of the band position
    localparam int DW         = 32;               // register and pressure width
    localparam int NUM_W      = DW + FRAC;        // divider dividend and quotient width
    localparam int DEN_W      = DW + 1;           // divider divisor and remainder width
    localparam int DIV_STAGES = NUM_W;            // one quotient bit per stage
    localparam int S_W        = SFRAC;            // band position s, Q0.30, always below 1
    localparam int SHIFT      = SFRAC - FRAC;
    localparam int NUM_DIV    = 5;                // dividers in the second pass
    localparam int LATENCY    = 2 * DIV_STAGES + 4;

    localparam logic [1:0] CFG_MIN_R  = 2'd0;
    localparam logic [1:0] CFG_MAX_R  = 2'd1;
    localparam logic [1:0] CFG_BAND_W = 2'd2;

    localparam logic [DW-1:0] RST_MIN_R  = DW'(1) << FRAC;
    localparam logic [DW-1:0] RST_MAX_R  = DW'(100) << FRAC;
    localparam logic [DW-1:0] RST_BAND_W = DW'(1) << FRAC;

    typedef enum logic [1:0] {
        REG_CLOSED = 2'd0,
        REG_BAND   = 2'd1,
        REG_OPEN   = 2'd2
    } t_region;

    typedef struct packed {
        logic signed [DW-1:0] inlet_pressure;
        logic signed [DW-1:0] outlet_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0] flow_term;
        logic signed [DW-1:0] flow_slope;
        logic [16:0]          valve_opening;
        logic [30:0]          opening_slope;
        t_region              band_region;
    } t_out_item;

    // register values with zero already replaced by one LSB
    typedef struct packed {
        logic [DW-1:0] min_r;
        logic [DW-1:0] max_r;
        logic [DW-1:0] eps;
    } t_cfg;

    // per-item side information travelling beside the dividers
    typedef struct packed {
        t_region        region;
        logic           neg;
        logic [DW-1:0]  mag;
        logic [S_W-1:0] s;
    } t_ctx;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] w;
    } t_dstep;

    // one restoring step: shift the next dividend bit into the remainder,
    // shift the quotient bit in at the bottom of the word
    function automatic t_dstep div_step(input logic [DEN_W-1:0] rem,
                                        input logic [NUM_W-1:0] w,
                                        input logic [DEN_W-1:0] den);
        t_dstep       res;
        logic [DEN_W:0] trial;
        logic         ge;
        trial = {rem, w[NUM_W-1]};
        ge    = (trial >= {1'b0, den});
        res.rem = ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        res.w   = {w[NUM_W-2:0], ge};
        return res;
    endfunction

endpackage

FILE: hdl/svc_front.sv
// Input stage: pressure difference, region choice and band numerator
module svc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  svc_pkg::t_in_item             i_item,
    input  svc_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [svc_pkg::DEN_W-1:0]     o_rem,
    output logic [svc_pkg::DEN_W-1:0]     o_den,
    output svc_pkg::t_ctx                 o_ctx
);
    logic signed [svc_pkg::DW:0]   dp;
    logic signed [svc_pkg::DW+1:0] dp2;
    logic signed [svc_pkg::DW+1:0] e;
    logic signed [svc_pkg::DW+1:0] u;
    logic [svc_pkg::DW:0]          mag;
    svc_pkg::t_ctx                 n_ctx;
    logic [svc_pkg::DEN_W-1:0]     n_rem;

    logic                          r_valid;
    logic [svc_pkg::DEN_W-1:0]     r_rem;
    logic [svc_pkg::DEN_W-1:0]     r_den;
    svc_pkg::t_ctx                 r_ctx;

    always_comb begin
        dp  = {i_item.inlet_pressure[svc_pkg::DW-1], i_item.inlet_pressure}
            - {i_item.outlet_pressure[svc_pkg::DW-1], i_item.outlet_pressure};
        dp2 = {dp, 1'b0};
        e   = {2'b00, i_cfg.eps};
        u   = dp2 + e;
        mag = dp[svc_pkg::DW] ? (svc_pkg::DW+1)'(-dp) : dp;
        n_ctx.neg = dp[svc_pkg::DW];
        n_ctx.mag = mag[svc_pkg::DW-1:0];
        n_ctx.s   = '0;
        n_rem     = '0;
        if (dp2 < -e) begin
            n_ctx.region = svc_pkg::REG_CLOSED;
        end else if (dp2 < e) begin
            n_ctx.region = svc_pkg::REG_BAND;
            n_rem        = u[svc_pkg::DEN_W-1:0];
        end else begin
            n_ctx.region = svc_pkg::REG_OPEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem <= n_rem;
        r_den <= {i_cfg.eps, 1'b0};
        r_ctx <= n_ctx;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_ctx   = r_ctx;
endmodule

FILE: hdl/svc_div.sv
// Pipelined restoring divider, one quotient bit per register stage
module svc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [svc_pkg::DEN_W-1:0]     i_rem,
    input  logic [svc_pkg::NUM_W-1:0]     i_num,
    input  logic [svc_pkg::DEN_W-1:0]     i_den,
    input  svc_pkg::t_ctx                 i_ctx,
    output logic                          o_valid,
    output logic [svc_pkg::NUM_W-1:0]     o_quo,
    output svc_pkg::t_ctx                 o_ctx
);
    localparam int N = svc_pkg::DIV_STAGES;

    logic                      a_vld [0:N];
    logic [svc_pkg::DEN_W-1:0] a_rem [0:N];
    logic [svc_pkg::NUM_W-1:0] a_w   [0:N];
    logic [svc_pkg::DEN_W-1:0] a_den [0:N];
    svc_pkg::t_ctx             a_ctx [0:N];

    assign a_vld[0] = i_valid;
    assign a_rem[0] = i_rem;
    assign a_w[0]   = i_num;
    assign a_den[0] = i_den;
    assign a_ctx[0] = i_ctx;

    for (genvar k = 0; k < N; k++) begin : g_stage
        svc_pkg::t_dstep           n_step;
        logic                      r_vld;
        logic [svc_pkg::DEN_W-1:0] r_rem;
        logic [svc_pkg::NUM_W-1:0] r_w;
        logic [svc_pkg::DEN_W-1:0] r_den;
        svc_pkg::t_ctx             r_ctx;

        always_comb begin
            n_step = svc_pkg::div_step(a_rem[k], a_w[k], a_den[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= a_vld[k];
            end
            r_rem <= n_step.rem;
            r_w   <= n_step.w;
            r_den <= a_den[k];
            r_ctx <= a_ctx[k];
        end

        assign a_vld[k+1] = r_vld;
        assign a_rem[k+1] = r_rem;
        assign a_w[k+1]   = r_w;
        assign a_den[k+1] = r_den;
        assign a_ctx[k+1] = r_ctx;
    end

    assign o_valid = a_vld[N];
    assign o_quo   = a_w[N];
    assign o_ctx   = a_ctx[N];
endmodule

FILE: hdl/svc_band.sv
// Band squares and scaling, then dividend and divisor choice for the second divide pass
module svc_band (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [svc_pkg::NUM_W-1:0]     i_quo,
    input  svc_pkg::t_ctx                 i_ctx,
    input  svc_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [svc_pkg::NUM_W-1:0]     o_num [0:svc_pkg::NUM_DIV-1],
    output logic [svc_pkg::DEN_W-1:0]     o_den [0:svc_pkg::NUM_DIV-1],
    output svc_pkg::t_ctx                 o_ctx
);
    localparam int S_W = svc_pkg::S_W;
    localparam int DW  = svc_pkg::DW;
    localparam int NW  = svc_pkg::NUM_W;

    logic [S_W-1:0]     s_in;
    logic [S_W:0]       t_in;
    logic [2*S_W-1:0]   sq_s;
    logic [2*S_W+1:0]   sq_t;
    svc_pkg::t_ctx      n_ctx1;

    logic               r_vld1;
    logic [S_W:0]       r_qs;
    logic [S_W:0]       r_qt;
    svc_pkg::t_ctx      r_ctx1;

    logic [S_W:0]       t_m2;
    logic [DW+S_W:0]    prod_s;
    logic [DW+S_W:0]    prod_t;
    logic [DW-1:0]      a_s;
    logic [DW-1:0]      a_t;
    logic [DW-1:0]      r_out;
    logic [NW-1:0]      n_num [0:svc_pkg::NUM_DIV-1];
    logic [svc_pkg::DEN_W-1:0] n_den [0:svc_pkg::NUM_DIV-1];

    logic               r_vld2;
    logic [NW-1:0]      r_num [0:svc_pkg::NUM_DIV-1];
    logic [svc_pkg::DEN_W-1:0] r_den [0:svc_pkg::NUM_DIV-1];
    svc_pkg::t_ctx      r_ctx2;

    // first stage: the two squares in Q0.30
    always_comb begin
        s_in   = i_quo[NW-1 -: S_W];
        t_in   = (S_W+1)'(1) << S_W;
        t_in   = t_in - {1'b0, s_in};
        sq_s   = s_in * s_in;
        sq_t   = t_in * t_in;
        n_ctx1   = i_ctx;
        n_ctx1.s = s_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
        end
        r_qs   <= (S_W+1)'(sq_s >> S_W);
        r_qt   <= (S_W+1)'(sq_t >> S_W);
        r_ctx1 <= n_ctx1;
    end

    // second stage: scale by eps, then pick what each divider works on
    always_comb begin
        t_m2   = ((S_W+1)'(1) << S_W) - {1'b0, r_ctx1.s};
        prod_s = i_cfg.eps * r_qs;
        prod_t = i_cfg.eps * r_qt;
        a_s    = DW'(prod_s >> S_W);
        a_t    = DW'(prod_t >> S_W);
        unique case (r_ctx1.region)
            svc_pkg::REG_CLOSED: r_out = i_cfg.max_r;
            svc_pkg::REG_OPEN:   r_out = i_cfg.min_r;
            default:             r_out = i_cfg.max_r;
        endcase

        n_num[1] = NW'(a_t) << svc_pkg::FRAC;
        n_den[1] = {i_cfg.max_r, 1'b0};
        n_num[3] = NW'(r_ctx1.s) << svc_pkg::FRAC;
        n_den[3] = {1'b0, i_cfg.min_r};
        n_num[4] = NW'(1) << (2 * svc_pkg::FRAC);
        n_den[4] = {1'b0, i_cfg.eps};
        if (r_ctx1.region == svc_pkg::REG_BAND) begin
            n_num[0] = NW'(a_s) << svc_pkg::FRAC;
            n_den[0] = {i_cfg.min_r, 1'b0};
            n_num[2] = NW'(t_m2) << svc_pkg::FRAC;
            n_den[2] = {1'b0, i_cfg.max_r};
        end else begin
            n_num[0] = NW'(r_ctx1.mag) << svc_pkg::FRAC;
            n_den[0] = {1'b0, r_out};
            n_num[2] = NW'(1) << (2 * svc_pkg::FRAC);
            n_den[2] = {1'b0, r_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_num  <= n_num;
        r_den  <= n_den;
        r_ctx2 <= r_ctx1;
    end

    assign o_valid = r_vld2;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_ctx   = r_ctx2;
endmodule

FILE: hdl/svc_back.sv
// Output stage: sign, saturation and region selection of the result word
module svc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [svc_pkg::NUM_W-1:0]     i_quo [0:svc_pkg::NUM_DIV-1],
    input  svc_pkg::t_ctx                 i_ctx,
    output logic                          o_valid,
    output svc_pkg::t_out_item            o_result
);
    localparam int NW = svc_pkg::NUM_W;
    localparam logic [NW-1:0] HALF  = NW'(1) << 31;
    localparam logic [NW-1:0] MAX31 = HALF - NW'(1);

    logic [31:0]            qc;
    logic signed [NW:0]     diff;
    logic [NW-svc_pkg::SHIFT:0] g;
    svc_pkg::t_out_item     n_res;

    logic                   r_valid;
    svc_pkg::t_out_item     r_res;

    always_comb begin
        qc   = (i_quo[0] > HALF) ? 32'(HALF) : i_quo[0][31:0];
        diff = $signed({1'b0, i_quo[0]}) - $signed({1'b0, i_quo[1]});
        g    = (NW-svc_pkg::SHIFT+1)'(i_quo[2] >> svc_pkg::SHIFT)
             + (NW-svc_pkg::SHIFT+1)'(i_quo[3] >> svc_pkg::SHIFT);
        n_res.band_region = i_ctx.region;
        unique case (i_ctx.region)
            svc_pkg::REG_BAND: begin
                if (diff > $signed((NW+1)'(MAX31))) begin
                    n_res.flow_term = 32'sh7FFF_FFFF;
                end else if (diff < -$signed((NW+1)'(HALF))) begin
                    n_res.flow_term = 32'sh8000_0000;
                end else begin
                    n_res.flow_term = diff[31:0];
                end
                n_res.flow_slope    = (g > (NW-svc_pkg::SHIFT+1)'(MAX31))
                                    ? 32'sh7FFF_FFFF : g[31:0];
                n_res.valve_opening = 17'(i_ctx.s >> svc_pkg::SHIFT);
                n_res.opening_slope = (i_quo[4] > MAX31) ? 31'h7FFF_FFFF : i_quo[4][30:0];
            end
            default: begin
                // outside the band: straight division, opening pinned to its end
                if (i_ctx.neg) begin
                    n_res.flow_term = 32'(-qc);
                end else begin
                    n_res.flow_term = qc[31] ? 32'sh7FFF_FFFF : qc;
                end
                n_res.flow_slope    = (i_quo[2] > MAX31) ? 32'sh7FFF_FFFF : i_quo[2][31:0];
                n_res.valve_opening = (i_ctx.region == svc_pkg::REG_OPEN)
                                    ? 17'(1) << svc_pkg::FRAC : 17'd0;
                n_res.opening_slope = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;
endmodule

FILE: hdl/smoothed_valve_conductance.sv
// Top level of the smoothed valve conductance block
// Use: raise i_start with an inlet/outlet pressure word on i_item; the word is
// taken at a clock edge where o_busy is low. o_busy is low from the cycle after
// reset on, so one word can be taken every cycle with no gaps.
// Each word gives one result word on o_result, marked by o_result_valid for a
// single cycle. After the accepting edge the word passes through one input
// stage, two passes through 48-stage restoring dividers (one quotient bit per
// stage; the second pass waits for the band position from the first), two
// multiplier stages between them and one output register before the strobe.
// Results leave in input order; the receiver cannot and need not hold them off.
// Configuration: i_cfg_valid with i_cfg_index and i_cfg_data writes one
// register (0 min resistance, 1 max resistance, 2 band width); o_cfg_ready is
// always high. Write only while no word is in flight. A zero register acts as
// one LSB.
// Reset (synchronous, active low) empties the pipeline and restores the
// register values 1.0, 100.0 and 1.0.
module smoothed_valve_conductance (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  svc_pkg::t_in_item     i_item,
    output logic                  o_result_valid,
    output svc_pkg::t_out_item    o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    `include "smoothed_valve_conductance_assert.svh"

    logic [svc_pkg::DW-1:0]    r_min_r;
    logic [svc_pkg::DW-1:0]    r_max_r;
    logic [svc_pkg::DW-1:0]    r_band_w;
    logic                      r_live;
    svc_pkg::t_cfg             cfg;
    logic                      accept;

    logic                      f_valid;
    logic [svc_pkg::DEN_W-1:0] f_rem;
    logic [svc_pkg::DEN_W-1:0] f_den;
    svc_pkg::t_ctx             f_ctx;

    logic                      d1_valid;
    logic [svc_pkg::NUM_W-1:0] d1_quo;
    svc_pkg::t_ctx             d1_ctx;

    logic                      b_valid;
    logic [svc_pkg::NUM_W-1:0] b_num [0:svc_pkg::NUM_DIV-1];
    logic [svc_pkg::DEN_W-1:0] b_den [0:svc_pkg::NUM_DIV-1];
    svc_pkg::t_ctx             b_ctx;

    logic                      d2_valid [0:svc_pkg::NUM_DIV-1];
    logic [svc_pkg::NUM_W-1:0] d2_quo   [0:svc_pkg::NUM_DIV-1];
    svc_pkg::t_ctx             d2_ctx   [0:svc_pkg::NUM_DIV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_r  <= svc_pkg::RST_MIN_R;
            r_max_r  <= svc_pkg::RST_MAX_R;
            r_band_w <= svc_pkg::RST_BAND_W;
            r_live   <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    svc_pkg::CFG_MIN_R:  r_min_r  <= i_cfg_data;
                    svc_pkg::CFG_MAX_R:  r_max_r  <= i_cfg_data;
                    svc_pkg::CFG_BAND_W: r_band_w <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        cfg.min_r = (r_min_r  == '0) ? svc_pkg::DW'(1) : r_min_r;
        cfg.max_r = (r_max_r  == '0) ? svc_pkg::DW'(1) : r_max_r;
        cfg.eps   = (r_band_w == '0) ? svc_pkg::DW'(1) : r_band_w;
    end

    assign o_busy      = !r_live;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    svc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .o_valid (f_valid),
        .o_rem   (f_rem),
        .o_den   (f_den),
        .o_ctx   (f_ctx)
    );

    // first pass: band position s = u / (2 eps)
    svc_div u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_rem   (f_rem),
        .i_num   ('0),
        .i_den   (f_den),
        .i_ctx   (f_ctx),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_ctx   (d1_ctx)
    );

    svc_band u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .i_quo   (d1_quo),
        .i_ctx   (d1_ctx),
        .i_cfg   (cfg),
        .o_valid (b_valid),
        .o_num   (b_num),
        .o_den   (b_den),
        .o_ctx   (b_ctx)
    );

    for (genvar k = 0; k < svc_pkg::NUM_DIV; k++) begin : g_div
        svc_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_valid),
            .i_rem   ('0),
            .i_num   (b_num[k]),
            .i_den   (b_den[k]),
            .i_ctx   (b_ctx),
            .o_valid (d2_valid[k]),
            .o_quo   (d2_quo[k]),
            .o_ctx   (d2_ctx[k])
        );
    end

    svc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d2_valid[0]),
        .i_quo    (d2_quo),
        .i_ctx    (d2_ctx[0]),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

    `SVC_ASSERT_SEQ(a_latency, accept, (##(svc_pkg::LATENCY) o_result_valid))
    `SVC_ASSERT_IMPLY(a_open_side, o_result_valid && o_result.band_region == svc_pkg::REG_OPEN,
        o_result.valve_opening == (17'(1) << svc_pkg::FRAC) && o_result.opening_slope == '0)
    `SVC_ASSERT_IMPLY(a_closed_side, o_result_valid && o_result.band_region == svc_pkg::REG_CLOSED,
        o_result.valve_opening == '0 && o_result.opening_slope == '0)
    `SVC_ASSERT_IMPLY(a_band_slope, o_result_valid && o_result.band_region == svc_pkg::REG_BAND,
        o_result.opening_slope != '0 && !o_result.flow_slope[31])
endmodule

FILE: verif/svc_checker.sv
// Checker for the smoothed valve conductance block: predicts each result word and compares it
`timescale 1ns / 100ps
module svc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  svc_pkg::t_in_item   i_item,
    input  logic                i_result_valid,
    input  svc_pkg::t_out_item  i_result,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [31:0]        min_r, max_r, band_w;
    svc_pkg::t_out_item expected_words[$];

    localparam longint unsigned POS_MAX = 64'd2147483647;
    localparam longint unsigned NEG_MAG = 64'd2147483648;

    function automatic logic [31:0] nonzero(logic [31:0] r);
        return (r == 0) ? 32'd1 : r;
    endfunction

    // (dp << F) / r, truncated toward zero and clamped to 32 bits signed
    function automatic logic [31:0] ratio_sat(longint dp, longint unsigned r);
        longint unsigned mag, q;
        mag = (dp < 0) ? longint'(-dp) : longint'(dp);
        q   = (mag << svc_pkg::FRAC) / r;
        if (dp < 0) return (q >= NEG_MAG) ? 32'h8000_0000 : 32'(-longint'(q));
        return (q > POS_MAX) ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    function automatic longint unsigned band_part(longint unsigned frac, longint unsigned eps,
                                                  longint unsigned r);
        longint unsigned sq, a;
        sq = (frac * frac) >> svc_pkg::SFRAC;
        a  = (eps * sq) >> svc_pkg::SFRAC;
        return (a << svc_pkg::FRAC) / (2 * r);
    endfunction

    function automatic svc_pkg::t_out_item valve_predict(svc_pkg::t_in_item it);
        svc_pkg::t_out_item res;
        longint unsigned    rn, rx, eps, u, s, t, g, q;
        longint             dp, e, fl;
        rn  = nonzero(min_r);
        rx  = nonzero(max_r);
        eps = nonzero(band_w);
        e   = longint'(eps);
        dp  = longint'(it.inlet_pressure) - longint'(it.outlet_pressure);
        if (2 * dp < -e) begin
            res.band_region   = svc_pkg::REG_CLOSED;
            res.flow_term     = ratio_sat(dp, rx);
            q = (64'd1 << (2 * svc_pkg::FRAC)) / rx;
            res.flow_slope    = (q > POS_MAX) ? 32'h7FFF_FFFF : 32'(q);
            res.valve_opening = '0;
            res.opening_slope = '0;
        end else if (2 * dp < e) begin
            u  = longint'(2 * dp + e);
            s  = (u << svc_pkg::SFRAC) / (2 * eps);
            t  = (64'd1 << svc_pkg::SFRAC) - s;
            fl = longint'(band_part(s, eps, rn)) - longint'(band_part(t, eps, rx));
            if (fl > longint'(POS_MAX)) fl = longint'(POS_MAX);
            if (fl < -longint'(NEG_MAG)) fl = -longint'(NEG_MAG);
            g = (((t << svc_pkg::FRAC) / rx) >> svc_pkg::SHIFT)
              + (((s << svc_pkg::FRAC) / rn) >> svc_pkg::SHIFT);
            q = (64'd1 << (2 * svc_pkg::FRAC)) / eps;
            res.band_region   = svc_pkg::REG_BAND;
            res.flow_term     = 32'(fl);
            res.flow_slope    = (g > POS_MAX) ? 32'h7FFF_FFFF : 32'(g);
            res.valve_opening = ((s >> svc_pkg::SHIFT) > 64'h1FFFF)
                              ? 17'h1FFFF : 17'(s >> svc_pkg::SHIFT);
            res.opening_slope = (q > POS_MAX) ? 31'h7FFF_FFFF : 31'(q);
        end else begin
            res.band_region   = svc_pkg::REG_OPEN;
            res.flow_term     = ratio_sat(dp, rn);
            q = (64'd1 << (2 * svc_pkg::FRAC)) / rn;
            res.flow_slope    = (q > POS_MAX) ? 32'h7FFF_FFFF : 32'(q);
            res.valve_opening = 17'(64'd1 << svc_pkg::FRAC);
            res.opening_slope = '0;
        end
        return res;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        svc_pkg::t_out_item want;
        if (!i_rst_n) begin
            min_r  <= svc_pkg::RST_MIN_R;
            max_r  <= svc_pkg::RST_MAX_R;
            band_w <= svc_pkg::RST_BAND_W;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_result_valid) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want !== i_result) begin
                        if (want.flow_term !== i_result.flow_term)
                            $display("%0t: flow_term expected %h actual %h",
                                     $time, want.flow_term, i_result.flow_term);
                        if (want.flow_slope !== i_result.flow_slope)
                            $display("%0t: flow_slope expected %h actual %h",
                                     $time, want.flow_slope, i_result.flow_slope);
                        if (want.valve_opening !== i_result.valve_opening)
                            $display("%0t: valve_opening expected %h actual %h",
                                     $time, want.valve_opening, i_result.valve_opening);
                        if (want.opening_slope !== i_result.opening_slope)
                            $display("%0t: opening_slope expected %h actual %h",
                                     $time, want.opening_slope, i_result.opening_slope);
                        if (want.band_region !== i_result.band_region)
                            $display("%0t: band_region expected %h actual %h",
                                     $time, want.band_region, i_result.band_region);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_words.push_back(valve_predict(i_item));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    svc_pkg::CFG_MIN_R:  min_r  <= i_cfg_data;
                    svc_pkg::CFG_MAX_R:  max_r  <= i_cfg_data;
                    svc_pkg::CFG_BAND_W: band_w <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the smoothed valve conductance block: stimulus and verdict
`timescale 1ns / 100ps
module tb;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    svc_pkg::t_in_item  i_item = '0;
    logic               o_result_valid;
    svc_pkg::t_out_item o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    int                 fail_count, pending;
    int                 cycles = 0;
    logic [31:0]        cur_eps = svc_pkg::RST_BAND_W;
    bit                 no_gaps = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    smoothed_valve_conductance u_top (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_item, .o_result_valid, .o_result,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    svc_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_item, .i_result_valid(o_result_valid),
        .i_result(o_result), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // drop start, then wait for every outstanding word
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        bit done;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = o_cfg_ready;
            @(posedge i_clk);
        end
        if (idx == svc_pkg::CFG_BAND_W) cur_eps = (val == 0) ? 32'd1 : val;
    endtask

    task automatic set_regs(logic [31:0] rmin, logic [31:0] rmax, logic [31:0] eps);
        drain();
        write_reg(svc_pkg::CFG_MIN_R, rmin);
        write_reg(svc_pkg::CFG_MAX_R, rmax);
        write_reg(svc_pkg::CFG_BAND_W, eps);
        i_cfg_valid <= 1'b0;
    endtask

    // hold start high across back-to-back words; lower it only for a gap
    task automatic send_word(logic [31:0] inlet, logic [31:0] outlet);
        bit taken;
        int gap;
        i_item  <= '{inlet_pressure: inlet, outlet_pressure: outlet};
        i_start <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_dp(longint dp);
        logic [31:0] outlet;
        outlet = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        send_word(32'(longint'($signed(outlet)) + dp), outlet);
    endtask

    task automatic random_words(int count);
        longint half;
        int     pick;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            half = longint'(cur_eps) / 2;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                send_word($urandom, $urandom);
            else if (pick < 3)
                send_dp(($urandom_range(0, 1) ? half : -half) + $urandom_range(0, 2) - 1);
            else
                send_dp(longint'($urandom_range(0, cur_eps)) - half
                        + longint'($urandom_range(0, 4)) - 2);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and band edges at reset values
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h0, 32'h0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_8000, 32'h0);
        send_word(32'h0000_7FFF, 32'h0);
        send_word(32'h0, 32'h0000_8000);
        send_word(32'h0, 32'h0000_8001);
        send_word(32'h0, 32'h0000_7FFF);
        // zero registers act as one LSB
        set_regs(32'h0, 32'h0, 32'h0);
        send_word(32'h0, 32'h0);
        send_word(32'h1, 32'h0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        // equal resistances, widest band
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h0, 32'h0);
        send_word(32'h1234_5678, 32'hEDCB_A988);
        // smallest open resistance, largest closed one
        set_regs(32'h1, 32'hFFFF_FFFF, 32'h0001_0000);
        send_word(32'h7FFF_FFFF, 32'h0);
        send_word(32'h8000_0000, 32'h0);
        send_word(32'h0, 32'h0);

        set_regs(svc_pkg::RST_MIN_R, svc_pkg::RST_MAX_R, svc_pkg::RST_BAND_W);
        random_words(100);
        set_regs(32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_words(100);
        set_regs(32'hFFFF_FFFF, 32'h1, 32'h1);
        random_words(100);
        set_regs(32'h0000_0100, 32'h0000_0100, 32'h0000_0400);
        random_words(50);
        drain();
        random_words(50);
        for (int p = 0; p < 5; p++) begin
            set_regs($urandom_range(1, 32'hFFFF_FFFF) >> $urandom_range(0, 31),
                     $urandom_range(1, 32'hFFFF_FFFF) >> $urandom_range(0, 31),
                     $urandom_range(1, 32'hFFFF_FFFF) >> $urandom_range(0, 31));
            random_words(90);
        end

        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (svc_pkg::LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/svc_pkg.sv
hdl/svc_front.sv
hdl/svc_div.sv
hdl/svc_band.sv
hdl/svc_back.sv
hdl/smoothed_valve_conductance.sv
verif/svc_checker.sv
verif/tb.sv
